### rtl/direction_to_wall_face_uv_top_assert.svh
// Assertion macros for the direction to wall-face block.
// Included by the modules that check their own logic; no other dependencies.
`ifndef DIRECTION_TO_WALL_FACE_UV_TOP_ASSERT_SVH
`define DIRECTION_TO_WALL_FACE_UV_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define DWFUV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset.
`define DWFUV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DWFUV_ASSERT(lbl, clk, rst, prop, msg)
`define DWFUV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/dwfuv_pkg.sv
// Shared types and constants of the direction to wall-face block.
// No dependencies.
package dwfuv_pkg;

  localparam int unsigned IN_W     = 16;  // direction component width
  localparam int unsigned M_W      = 16;  // major magnitude, 1..32768
  localparam int unsigned N_W      = 17;  // numerator, 0..2m
  localparam int unsigned R_W      = 15;  // remainder, always below m
  localparam int unsigned Q_W      = 17;  // coordinate, 0..65536
  localparam int unsigned NUM_CELLS = Q_W;  // one quotient bit per cell

  typedef enum logic [2:0] {
    FACE_MINUS_Z = 3'd0,
    FACE_PLUS_Z  = 3'd1,
    FACE_MINUS_X = 3'd2,
    FACE_PLUS_X  = 3'd3,
    FACE_NONE    = 3'd4
  } face_t;

  // Payload carried along the divider chain, both lanes side by side.
  typedef struct packed {
    face_t            face;
    logic [M_W-1:0]   m;
    logic [R_W-1:0]   ru;
    logic [R_W-1:0]   rv;
    logic [Q_W-1:0]   du;
    logic [Q_W-1:0]   dv;
    logic [Q_W-1:0]   qu;
    logic [Q_W-1:0]   qv;
  } stage_t;

endpackage

### rtl/dwfuv_vec_if.sv
// Input channel: one direction vector per transfer.
// Depends on dwfuv_pkg.
interface dwfuv_vec_if;
  logic                              valid;
  logic                              ready;
  logic signed [dwfuv_pkg::IN_W-1:0] vec_x;
  logic signed [dwfuv_pkg::IN_W-1:0] vec_y;
  logic signed [dwfuv_pkg::IN_W-1:0] vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

### rtl/dwfuv_uv_if.sv
// Output channel: one texture coordinate pair and face code per transfer.
// Depends on dwfuv_pkg.
interface dwfuv_uv_if;
  logic                       valid;
  logic                       ready;
  logic [dwfuv_pkg::Q_W-1:0]  tex_u;
  logic [dwfuv_pkg::Q_W-1:0]  tex_v;
  logic [2:0]                 face;

  modport source (output valid, output tex_u, output tex_v, output face, input ready);
  modport sink   (input valid, input tex_u, input tex_v, input face, output ready);
endinterface

### rtl/dwfuv_classify.sv
// Front stage: wall selection, major magnitude and numerators, registered.
// Depends on dwfuv_pkg and the assertion header.
`include "direction_to_wall_face_uv_top_assert.svh"
module dwfuv_classify (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [dwfuv_pkg::IN_W-1:0] vec_x,
  input  logic signed [dwfuv_pkg::IN_W-1:0] vec_y,
  input  logic signed [dwfuv_pkg::IN_W-1:0] vec_z,
  output logic                              valid,
  input  logic                              dn_ready,
  output dwfuv_pkg::stage_t                 st
);

  logic signed [17:0] x, y, z;
  logic signed [17:0] mag, nu, nv;
  dwfuv_pkg::face_t   face_sel;
  dwfuv_pkg::stage_t  st_next;

  assign x = 18'(vec_x);
  assign y = 18'(vec_y);
  assign z = 18'(vec_z);

  // Walls tested in fixed order; the first whose bounds hold wins.
  always_comb begin
    face_sel = dwfuv_pkg::FACE_NONE;
    mag      = 18'sd1;
    nu       = 18'sd0;
    priority if (z < 0 && x >= z && x < -z && y >= z && y <= -z) begin
      face_sel = dwfuv_pkg::FACE_MINUS_Z;
      mag      = -z;
      nu       = x - z;
    end else if (z > 0 && x > -z && x <= z && y >= -z && y <= z) begin
      face_sel = dwfuv_pkg::FACE_PLUS_Z;
      mag      = z;
      nu       = z - x;
    end else if (x < 0 && z > x && z <= -x && y >= x && y <= -x) begin
      face_sel = dwfuv_pkg::FACE_MINUS_X;
      mag      = -x;
      nu       = -x - z;
    end else if (x > 0 && z >= -x && z < x && y >= -x && y <= x) begin
      face_sel = dwfuv_pkg::FACE_PLUS_X;
      mag      = x;
      nu       = x + z;
    end else begin
      // No wall: m of one and zero numerators give zero coordinates.
      face_sel = dwfuv_pkg::FACE_NONE;
      mag      = 18'sd1;
      nu       = 18'sd0;
    end
  end

  assign nv = (face_sel == dwfuv_pkg::FACE_NONE) ? 18'sd0 : mag + y;

  // Quotient bits above 16 are zero, so start with n/4 as the remainder.
  always_comb begin
    st_next.face = face_sel;
    st_next.m    = mag[dwfuv_pkg::M_W-1:0];
    st_next.ru   = nu[dwfuv_pkg::N_W-1:2];
    st_next.rv   = nv[dwfuv_pkg::N_W-1:2];
    st_next.du   = {nu[1:0], 15'd0};
    st_next.dv   = {nv[1:0], 15'd0};
    st_next.qu   = '0;
    st_next.qv   = '0;
  end

  assign in_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st <= st_next;
    end
  end

  `DWFUV_ASSERT(a_cls_m_nonzero, clk, rst, valid |-> (st.m != '0), "classify: zero magnitude")
  `DWFUV_ASSERT(a_cls_none_zero, clk, rst,
    (valid && st.face == dwfuv_pkg::FACE_NONE) |-> (st.ru == '0 && st.du == '0 && st.rv == '0),
    "classify: no-wall item carries a numerator")

endmodule

### rtl/dwfuv_div_cell.sv
// One cell of the divider chain: one quotient bit for both lanes per cell.
// Depends on dwfuv_pkg and the assertion header.
`include "direction_to_wall_face_uv_top_assert.svh"
module dwfuv_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  dwfuv_pkg::stage_t up_st,
  output logic              valid,
  input  logic              dn_ready,
  output dwfuv_pkg::stage_t st
);

  logic [dwfuv_pkg::M_W-1:0] tu, tv, du_diff, dv_diff;
  logic                      bu, bv;
  dwfuv_pkg::stage_t         st_next;

  // Shift in the next dividend bit, subtract when the divisor fits.
  assign tu = {up_st.ru, up_st.du[dwfuv_pkg::Q_W-1]};
  assign tv = {up_st.rv, up_st.dv[dwfuv_pkg::Q_W-1]};
  assign bu = (tu >= up_st.m);
  assign bv = (tv >= up_st.m);
  assign du_diff = tu - up_st.m;
  assign dv_diff = tv - up_st.m;

  always_comb begin
    st_next      = up_st;
    st_next.ru   = bu ? du_diff[dwfuv_pkg::R_W-1:0] : tu[dwfuv_pkg::R_W-1:0];
    st_next.rv   = bv ? dv_diff[dwfuv_pkg::R_W-1:0] : tv[dwfuv_pkg::R_W-1:0];
    st_next.du   = {up_st.du[dwfuv_pkg::Q_W-2:0], 1'b0};
    st_next.dv   = {up_st.dv[dwfuv_pkg::Q_W-2:0], 1'b0};
    st_next.qu   = {up_st.qu[dwfuv_pkg::Q_W-2:0], bu};
    st_next.qv   = {up_st.qv[dwfuv_pkg::Q_W-2:0], bv};
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      st <= st_next;
    end
  end

  `DWFUV_ASSERT(a_cell_rem_bound, clk, rst,
    valid |-> ({1'b0, st.ru} < st.m && {1'b0, st.rv} < st.m),
    "div cell: remainder not below divisor")
  `DWFUV_ASSERT(a_cell_hold, clk, rst, (valid && !dn_ready) |=> (valid && $stable(st)),
    "div cell: stalled item changed")

endmodule

### rtl/direction_to_wall_face_uv_top.sv
// Direction to wall-face texture coordinates, top level.
// Depends on dwfuv_pkg, dwfuv_vec_if, dwfuv_uv_if, dwfuv_classify, dwfuv_div_cell.
//
// Takes one direction vector per cycle while the output is not stalled and
// returns its wall face and (u,v) in unsigned 1.16 fixed point, one result
// per cycle sustained. A registered front stage picks the wall and forms m
// and the numerators, then a chain of 17 divider cells follows, each
// producing one quotient bit of both coordinates. The last cell
// is the output register; every cell has its own valid and takes a new item
// when it is empty or its successor moves, so bubbles close up under stalls.
// A vector that hits no side wall returns u = v = 0 and face code 4.
module direction_to_wall_face_uv_top (
  input  logic        clk,
  input  logic        rst,
  dwfuv_vec_if.sink   dir,
  dwfuv_uv_if.source  uv
);

  logic              valid_c [dwfuv_pkg::NUM_CELLS+1];
  logic              ready_c [dwfuv_pkg::NUM_CELLS+1];
  dwfuv_pkg::stage_t st_c    [dwfuv_pkg::NUM_CELLS+1];

  dwfuv_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dir.valid),
    .in_ready (dir.ready),
    .vec_x    (dir.vec_x),
    .vec_y    (dir.vec_y),
    .vec_z    (dir.vec_z),
    .valid    (valid_c[0]),
    .dn_ready (ready_c[0]),
    .st       (st_c[0])
  );

  for (genvar k = 0; k < dwfuv_pkg::NUM_CELLS; k++) begin : g_cell
    dwfuv_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid_c[k]),
      .up_ready (ready_c[k]),
      .up_st    (st_c[k]),
      .valid    (valid_c[k+1]),
      .dn_ready (ready_c[k+1]),
      .st       (st_c[k+1])
    );
  end

  assign ready_c[dwfuv_pkg::NUM_CELLS] = uv.ready;
  assign uv.valid = valid_c[dwfuv_pkg::NUM_CELLS];
  assign uv.tex_u = st_c[dwfuv_pkg::NUM_CELLS].qu;
  assign uv.tex_v = st_c[dwfuv_pkg::NUM_CELLS].qv;
  assign uv.face  = st_c[dwfuv_pkg::NUM_CELLS].face;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for direction_to_wall_face_uv_top: directed and random directions, three idle mixes.
// A scoreboard class predicts face and (u,v). Depends on dwfuv_pkg, dwfuv_vec_if, dwfuv_uv_if.
module testbench;
  import dwfuv_pkg::*;

  typedef struct {
    logic [Q_W-1:0] tex_u;
    logic [Q_W-1:0] tex_v;
    face_t          face;
  } wall_uv_t;

  class uv_scoreboard;
    wall_uv_t pending_uv[$];
    int       errors = 0;

    // floor(65536 * n / (2m)), exact on integers
    function logic [Q_W-1:0] to_fixed(int n, int m);
      longint q;
      q = (longint'(n) <<< 15) / m;
      return q[Q_W-1:0];
    endfunction

    function wall_uv_t project_to_wall(int x, int y, int z);
      wall_uv_t r;
      int m;
      int nu;
      m = 0;
      nu = 0;
      r.face = FACE_NONE;
      if (z < 0) begin
        m = -z;
        if (x >= -m && x < m && y >= -m && y <= m) begin
          nu = m + x;
          r.face = FACE_MINUS_Z;
        end
      end else if (z > 0) begin
        m = z;
        if (x > -m && x <= m && y >= -m && y <= m) begin
          nu = m - x;
          r.face = FACE_PLUS_Z;
        end
      end
      // fall through to the x walls only when no z wall took the vector
      if (r.face == FACE_NONE) begin
        if (x < 0) begin
          m = -x;
          if (z > -m && z <= m && y >= -m && y <= m) begin
            nu = m - z;
            r.face = FACE_MINUS_X;
          end
        end else if (x > 0) begin
          m = x;
          if (z >= -m && z < m && y >= -m && y <= m) begin
            nu = m + z;
            r.face = FACE_PLUS_X;
          end
        end
      end
      if (r.face == FACE_NONE) begin
        r.tex_u = '0;
        r.tex_v = '0;
      end else begin
        r.tex_u = to_fixed(nu, m);
        r.tex_v = to_fixed(m + y, m);
      end
      return r;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
    endtask

    function void note_vec(logic signed [IN_W-1:0] x, y, z);
      pending_uv.push_back(project_to_wall(x, y, z));
    endfunction

    task check_uv(logic [Q_W-1:0] u, v, logic [2:0] f);
      wall_uv_t e;
      if (pending_uv.size() == 0) begin
        report($sformatf("unexpected transfer u=%0d v=%0d face=%0d", u, v, f));
        return;
      end
      e = pending_uv.pop_front();
      if (u !== e.tex_u || v !== e.tex_v || f !== e.face)
        report($sformatf("got u=%0d v=%0d face=%0d, want u=%0d v=%0d face=%0d",
                         u, v, f, e.tex_u, e.tex_v, e.face));
    endtask
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   sink_idle_pct;

  dwfuv_vec_if dir ();
  dwfuv_uv_if  uv ();

  uv_scoreboard sb = new;

  direction_to_wall_face_uv_top u_dut (
    .clk (clk),
    .rst (rst),
    .dir (dir),
    .uv  (uv)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: stall at random at the falling edge.
  initial begin
    uv.ready = 1'b0;
    forever begin
      @(negedge clk);
      uv.ready = !rst && ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (dir.valid && dir.ready) sb.note_vec(dir.vec_x, dir.vec_y, dir.vec_z);
      if (uv.valid && uv.ready) sb.check_uv(uv.tex_u, uv.tex_v, uv.face);
    end
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Pick a minor component around the bounds of magnitude m.
  function automatic int edge_pick(int m);
    int v;
    case ($urandom_range(0, 6))
      0: v = -m;
      1: v = m;
      2: v = -m + 1;
      3: v = m - 1;
      4: v = m + 1;
      5: v = -m - 1;
      default: v = int'($urandom_range(0, 2 * m)) - m;
    endcase
    return clamp16(v);
  endfunction

  task automatic make_vec(output logic signed [IN_W-1:0] x, y, z);
    int m;
    int major;
    m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 32768);
    major = $urandom_range(0, 1) ? clamp16(m) : -m;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        x = IN_W'($urandom);
        y = IN_W'($urandom);
        z = IN_W'($urandom);
      end
      3, 4: begin
        x = IN_W'(int'($urandom_range(0, 12)) - 6);
        y = IN_W'(int'($urandom_range(0, 12)) - 6);
        z = IN_W'(int'($urandom_range(0, 12)) - 6);
      end
      9: begin
        // aim up or down
        y = IN_W'(major);
        x = IN_W'(edge_pick(m));
        z = IN_W'(edge_pick(m));
      end
      default: begin
        y = IN_W'(edge_pick(m));
        if ($urandom_range(0, 1)) begin
          z = IN_W'(major);
          x = IN_W'(edge_pick(m));
        end else begin
          x = IN_W'(major);
          z = IN_W'(edge_pick(m));
        end
      end
    endcase
  endtask

  // Entered and left at a falling edge.
  task automatic send_vec(input logic signed [IN_W-1:0] x, y, z);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      dir.valid = 1'b0;
      @(negedge clk);
    end
    dir.valid = 1'b1;
    dir.vec_x = x;
    dir.vec_y = y;
    dir.vec_z = z;
    @(posedge clk);
    while (!dir.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every expected result has come back.
  task automatic wait_drained();
    dir.valid = 1'b0;
    while (sb.pending_uv.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic signed [IN_W-1:0] x, y, z;
    rst = 1'b1;
    dir.valid = 1'b0;
    dir.vec_x = '0;
    dir.vec_y = '0;
    dir.vec_z = '0;
    src_idle_pct = 28;
    sink_idle_pct = 71;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no wall: zero, up, down, y just outside
    send_vec(0, 0, 0);
    send_vec(0, 1000, 0);
    send_vec(0, -1000, 0);
    send_vec(100, 101, 0);
    send_vec(32767, -32768, 0);
    // wall centers
    send_vec(0, 0, -100);
    send_vec(0, 0, 100);
    send_vec(-100, 0, 0);
    send_vec(100, 0, 0);
    send_vec(1, 0, 0);
    // most negative inputs and full scale
    send_vec(-32768, -32768, -32768);
    send_vec(32767, 32767, -32768);
    send_vec(-32768, 32767, 32767);
    send_vec(32767, -32767, 32767);
    send_vec(32767, 32767, 32767);
    send_vec(-32768, 0, 0);
    send_vec(0, -32768, -32768);
    // shared edges between walls
    send_vec(-32767, 32767, 32767);
    send_vec(100, 0, -100);
    send_vec(-100, 0, -100);
    send_vec(100, 100, 100);
    send_vec(-100, -100, 100);
    send_vec(100, 0, -101);
    send_vec(-1, -1, -1);
    send_vec(1, 1, 1);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 28;
          sink_idle_pct = 71;
        end
        1: begin
          src_idle_pct = 71;
          sink_idle_pct = 28;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      repeat (500) begin
        make_vec(x, y, z);
        send_vec(x, y, z);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
